[hw/rtl/bsa_pkg.sv]
`default_nettype none

package bsa_pkg;

    localparam int MAX_SLOTS = 64;
    localparam int MAX_DATA  = 64;
    localparam int IDX_W     = 6;
    localparam int CNT_W     = 7;
    localparam int FUNC_W    = 3;
    localparam int STAT_W    = 2;
    localparam int GRP_W     = 8;

    localparam logic [CNT_W-1:0] SLOT_COUNT_RST = 7'd64;

    localparam logic [FUNC_W-1:0] FN_ALLOC   = 3'd0;
    localparam logic [FUNC_W-1:0] FN_ADD     = 3'd1;
    localparam logic [FUNC_W-1:0] FN_UPDATE  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_DESTROY = 3'd3;
    localparam logic [FUNC_W-1:0] FN_QUERY   = 3'd4;
    localparam logic [FUNC_W-1:0] FN_SYNC    = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD  = 2'd2;
    localparam logic [STAT_W-1:0] ST_NONE = 2'd3;

    typedef struct packed {
        logic latch;
        logic exec;
        logic sync_rd;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic is_sync;
        logic found;
    } t_sts;

endpackage

`default_nettype wire

[hw/rtl/bsa_find.sv]
`default_nettype none

module bsa_find #(
    parameter int SLOTS = bsa_pkg::MAX_SLOTS
) (
    input  wire logic                     i_clk,
    input  wire logic [SLOTS-1:0]         i_vec,
    output logic                          o_found,
    output logic [bsa_pkg::IDX_W-1:0]     o_idx
);

    localparam int GW     = bsa_pkg::GRP_W;
    localparam int GROUPS = (SLOTS + GW - 1) / GW;
    localparam int PAD    = GROUPS * GW;

    logic [PAD-1:0] pad;
    logic [GROUPS-1:0] r_any;
    logic [2:0] r_low [GROUPS];

    function automatic logic [2:0] low8(input logic [GW-1:0] v);
        logic [2:0] res;
        res = 3'd0;
        for (int i = GW - 1; i >= 0; i--) begin
            if (v[i]) begin
                res = 3'(i);
            end
        end
        return res;
    endfunction

    assign pad = PAD'(i_vec);

    // first level: per-group summary
    always_ff @(posedge i_clk) begin
        for (int g = 0; g < GROUPS; g++) begin
            r_any[g] <= |pad[g*GW +: GW];
            r_low[g] <= low8(pad[g*GW +: GW]);
        end
    end

    // second level: lowest non-empty group
    always_comb begin
        o_found = 1'b0;
        o_idx   = '0;
        for (int g = GROUPS - 1; g >= 0; g--) begin
            if (r_any[g]) begin
                o_found = 1'b1;
                o_idx   = {3'(g), r_low[g]};
            end
        end
    end

endmodule

`default_nettype wire

[hw/rtl/bsa_datapath.sv]
`default_nettype none

module bsa_datapath #(
    parameter int SLOTS     = bsa_pkg::MAX_SLOTS,
    parameter int DATA_BITS = bsa_pkg::MAX_DATA
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [bsa_pkg::CNT_W-1:0]     i_cfg_wr_data,
    input  wire logic [bsa_pkg::FUNC_W-1:0]    i_func,
    input  wire logic                          i_handle_valid,
    input  wire logic [bsa_pkg::IDX_W-1:0]     i_handle_index,
    input  wire logic [bsa_pkg::MAX_DATA-1:0]  i_entry_data,
    input  wire bsa_pkg::t_cmd                 i_cmd,
    output bsa_pkg::t_sts                      o_sts,
    output logic [bsa_pkg::STAT_W-1:0]         o_status,
    output logic [bsa_pkg::IDX_W-1:0]          o_slot_index,
    output logic                               o_used_flag,
    output logic [bsa_pkg::MAX_DATA-1:0]       o_synced_data,
    output logic                               o_last
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = bsa_pkg::CNT_W;

    logic [bsa_pkg::FUNC_W-1:0] r_func;
    logic                       r_hv;
    logic [bsa_pkg::IDX_W-1:0]  r_hidx;
    logic [DATA_BITS-1:0]       r_data;

    logic [CW-1:0]    r_slot_count;
    logic [SLOTS-1:0] r_used;
    logic [SLOTS-1:0] r_dirty;
    logic [SLOTS-1:0] r_written;

    logic [DATA_BITS-1:0] mem [SLOTS];
    logic [DATA_BITS-1:0] r_rd;
    logic                 r_rd_ok;
    logic [bsa_pkg::IDX_W-1:0] r_sidx;

    logic [bsa_pkg::STAT_W-1:0] r_status;
    logic [bsa_pkg::IDX_W-1:0]  r_slot_index;
    logic                       r_used_flag;
    logic [DATA_BITS-1:0]       r_synced;
    logic                       r_last;

    logic [bsa_pkg::STAT_W-1:0] n_status;
    logic [bsa_pkg::IDX_W-1:0]  n_slot_index;
    logic                       n_used_flag;

    logic [CW-1:0]    act_n;
    logic [SLOTS-1:0] act;
    logic [SLOTS-1:0] search;
    logic             handle_ok;
    logic             f_found;
    logic [bsa_pkg::IDX_W-1:0] f_idx;
    logic             is_alloc;
    logic             do_alloc;
    logic             do_update;
    logic             do_destroy;
    logic             wr_en;
    logic [IW-1:0]    wr_addr;

    assign act_n = (r_slot_count > CW'(SLOTS)) ? CW'(SLOTS) : r_slot_count;

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            act[i] = CW'(i) < act_n;
        end
    end

    assign search = (r_func == bsa_pkg::FN_SYNC) ? (r_dirty & act) : (~r_used & act);

    bsa_find #(
        .SLOTS (SLOTS)
    ) u_find (
        .i_clk   (i_clk),
        .i_vec   (search),
        .o_found (f_found),
        .o_idx   (f_idx)
    );

    assign handle_ok = r_hv && ({1'b0, r_hidx} < act_n);
    assign is_alloc  = (r_func == bsa_pkg::FN_ALLOC) || (r_func == bsa_pkg::FN_ADD);
    assign do_alloc  = i_cmd.exec && is_alloc && f_found;
    assign do_update = i_cmd.exec && (r_func == bsa_pkg::FN_UPDATE) && handle_ok;
    assign do_destroy = i_cmd.exec && (r_func == bsa_pkg::FN_DESTROY) && handle_ok;
    assign wr_en     = (do_alloc && (r_func == bsa_pkg::FN_ADD)) || do_update;
    assign wr_addr   = do_update ? r_hidx[IW-1:0] : f_idx[IW-1:0];

    assign o_sts.is_sync = (r_func == bsa_pkg::FN_SYNC);
    assign o_sts.found   = f_found;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_func <= i_func;
            r_hv   <= i_handle_valid;
            r_hidx <= i_handle_index;
            r_data <= i_entry_data[DATA_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_count <= bsa_pkg::SLOT_COUNT_RST;
            r_used       <= '0;
            r_dirty      <= '0;
            r_written    <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_slot_count <= i_cfg_wr_data;
            end
            if (do_alloc) begin
                r_used[f_idx[IW-1:0]]  <= 1'b1;
                r_dirty[f_idx[IW-1:0]] <= 1'b1;
            end
            if (do_update) begin
                r_dirty[r_hidx[IW-1:0]] <= 1'b1;
            end
            if (do_destroy) begin
                r_used[r_hidx[IW-1:0]] <= 1'b0;
            end
            if (wr_en) begin
                r_written[wr_addr] <= 1'b1;
            end
            if (i_cmd.sync_rd) begin
                r_dirty[f_idx[IW-1:0]] <= 1'b0;
            end
        end
    end

    // entry store, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= r_data;
        end
        if (i_cmd.sync_rd) begin
            r_rd    <= mem[f_idx[IW-1:0]];
            r_rd_ok <= r_written[f_idx[IW-1:0]];
            r_sidx  <= f_idx;
        end
    end

    always_comb begin
        n_status     = bsa_pkg::ST_BAD;
        n_slot_index = '0;
        n_used_flag  = 1'b0;
        case (r_func)
            bsa_pkg::FN_ALLOC, bsa_pkg::FN_ADD: begin
                if (f_found) begin
                    n_status     = bsa_pkg::ST_OK;
                    n_slot_index = f_idx;
                end else begin
                    n_status = bsa_pkg::ST_FULL;
                end
            end
            bsa_pkg::FN_UPDATE, bsa_pkg::FN_DESTROY: begin
                n_status     = handle_ok ? bsa_pkg::ST_OK : bsa_pkg::ST_BAD;
                n_slot_index = r_hidx;
            end
            bsa_pkg::FN_QUERY: begin
                n_status     = handle_ok ? bsa_pkg::ST_OK : bsa_pkg::ST_BAD;
                n_slot_index = r_hidx;
                n_used_flag  = handle_ok && r_used[r_hidx[IW-1:0]];
            end
            bsa_pkg::FN_SYNC: begin
                n_status = bsa_pkg::ST_NONE;
            end
            default: begin
                n_status = bsa_pkg::ST_BAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status     <= n_status;
            r_slot_index <= n_slot_index;
            r_used_flag  <= n_used_flag;
            r_synced     <= '0;
            r_last       <= 1'b1;
        end else if (i_cmd.emit) begin
            r_status     <= bsa_pkg::ST_OK;
            r_slot_index <= r_sidx;
            r_used_flag  <= 1'b0;
            r_synced     <= r_rd_ok ? r_rd : '0;
            r_last       <= !f_found;
        end
    end

    assign o_status      = r_status;
    assign o_slot_index  = r_slot_index;
    assign o_used_flag   = r_used_flag;
    assign o_synced_data = bsa_pkg::MAX_DATA'(r_synced);
    assign o_last        = r_last;

endmodule

`default_nettype wire

[hw/rtl/bsa_ctrl.sv]
`default_nettype none

module bsa_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    input  wire bsa_pkg::t_sts i_sts,
    output bsa_pkg::t_cmd      o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_READ   = 3'd3;
    localparam logic [2:0] S_EMIT   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (i_sts.is_sync && i_sts.found) begin
                    o_cmd.sync_rd = 1'b1;
                    n_state       = S_READ;
                end else if (out_free) begin
                    o_cmd.exec  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_READ: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = i_sts.found ? S_DECIDE : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

[hw/rtl/bitmap_slot_allocator_dirty.sv]
// slot allocator with used and dirty bitmaps over a store of entries
// input channel: i_in_valid / o_in_stall carry func, handle and entry data;
// a transfer happens on a rising edge with valid high and stall low
// output channel: o_out_valid / i_out_stall carry status, slot index, used
// flag, synced data and last; o_out_valid is registered
// i_cfg_wr_en / i_cfg_wr_data write the active slot count; the user must
// write it only while idle, as the block does not enforce this
// a single-result function passes SCAN and DECIDE, then loads its result
// register once the output is free; the block takes one item at a time, so
// the next input transfer is possible the cycle after the result is loaded
// sync: each dirty slot goes through find, store read and emit, over the
// two-level free/dirty search and the registered store read port
// a stalled receiver holds the result register; the block waits for it
// before loading another result and holds o_in_stall high meanwhile
// reset clears the bitmaps and the per-entry written bits at once, so the
// store reads as zero with no clearing pass; slot count resets to 64
`default_nettype none

module bitmap_slot_allocator_dirty #(
    parameter int SLOTS     = bsa_pkg::MAX_SLOTS,
    parameter int DATA_BITS = bsa_pkg::MAX_DATA
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [bsa_pkg::CNT_W-1:0]     i_cfg_wr_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [bsa_pkg::FUNC_W-1:0]    i_func,
    input  wire logic                          i_handle_valid,
    input  wire logic [bsa_pkg::IDX_W-1:0]     i_handle_index,
    input  wire logic [bsa_pkg::MAX_DATA-1:0]  i_entry_data,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [bsa_pkg::STAT_W-1:0]         o_status,
    output logic [bsa_pkg::IDX_W-1:0]          o_slot_index,
    output logic                               o_used_flag,
    output logic [bsa_pkg::MAX_DATA-1:0]       o_synced_data,
    output logic                               o_last
);

    bsa_pkg::t_cmd cmd;
    bsa_pkg::t_sts sts;

    bsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    bsa_datapath #(
        .SLOTS     (SLOTS),
        .DATA_BITS (DATA_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_func         (i_func),
        .i_handle_valid (i_handle_valid),
        .i_handle_index (i_handle_index),
        .i_entry_data   (i_entry_data),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_status       (o_status),
        .o_slot_index   (o_slot_index),
        .o_used_flag    (o_used_flag),
        .o_synced_data  (o_synced_data),
        .o_last         (o_last)
    );

    // one item in flight: an input transfer stalls the next cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while busy");

    // only sync gives results that are not last, and those are ok
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last) |-> (o_status == bsa_pkg::ST_OK))
        else $error("non-last result with error status");

    // nothing-dirty is always the single result of its sync
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == bsa_pkg::ST_NONE)) |-> (o_last && (o_slot_index == '0)))
        else $error("nothing-dirty result malformed");

    // a new result never replaces one the receiver has not taken
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("stalled result dropped");

endmodule

`default_nettype wire
